@@ rtl/core/cisd_pkg.sv @@
// Package for the compressed integer stream decoder.
// Holds the format constants, the assembler-to-packer struct and the bit reversal.
// Depends on nothing; every module of the decoder imports it.
package cisd_pkg;

  // Stream format constants.
  localparam logic [7:0] LowByteLimit  = 8'd192;
  localparam int         ShiftPerByte  = 6;
  localparam logic [2:0] MaxExtraBytes = 3'd4;

  // Width of the extra-byte shift amount: 7 * 6 = 42 fits in 6 bits.
  localparam int ShiftW = 6;

  // Masks of the bit reversal swap stages.
  localparam logic [31:0] MaskOdd1  = 32'h5555_5555;
  localparam logic [31:0] MaskOdd2  = 32'h3333_3333;
  localparam logic [31:0] MaskOdd4  = 32'h0F0F_0F0F;
  localparam logic [31:0] MaskByte1 = 32'h0000_FF00;

  // A finished value handed from the assembler to the packer.
  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } value_beat_t;

  // Full 32-bit bit reversal by swap stages of 1, 2, 4 bits and a byte swap.
  function automatic logic [31:0] bit_reverse32(input logic [31:0] x);
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s4;
    s1 = ((x & MaskOdd1) << 1) | ((x >> 1) & MaskOdd1);
    s2 = ((s1 & MaskOdd2) << 2) | ((s1 >> 2) & MaskOdd2);
    s4 = ((s2 & MaskOdd4) << 4) | ((s2 >> 4) & MaskOdd4);
    return (s4 << 24) | ((s4 & MaskByte1) << 8) | ((s4 >> 8) & MaskByte1) | (s4 >> 24);
  endfunction

endpackage

@@ rtl/core/cisd_accum.sv @@
// Value assembler of the compressed integer stream decoder.
// Keeps the running sum and extra-byte count and flags each finished value.
// Depends on cisd_pkg.
module cisd_accum
  import cisd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  byte_i,
  output value_beat_t value_o
);

  logic [31:0]       sum_q, sum_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [ShiftW-1:0] shift_amt;
  logic [31:0]       addend;
  logic [31:0]       sum_new;
  logic              is_low;

  assign is_low    = byte_i < LowByteLimit;
  assign shift_amt = ShiftW'(cnt_q * ShiftPerByte);
  // Shifts of 32 or more push the byte entirely out of the 32-bit sum.
  assign addend    = shift_amt[ShiftW-1] ? 32'd0 : ({24'd0, byte_i} << shift_amt[4:0]);
  assign sum_new   = sum_q + addend;

  always_comb begin
    sum_d         = sum_q;
    cnt_d         = cnt_q;
    value_o.done  = 1'b0;
    value_o.value = sum_new;
    if (cnt_q == 3'd0) begin
      value_o.value = {24'd0, byte_i};
      if (is_low) begin
        value_o.done = fire_i;
      end else if (fire_i) begin
        sum_d = {24'd0, byte_i};
        cnt_d = 3'd1;
      end
    end else if (is_low || cnt_q >= MaxExtraBytes) begin
      value_o.done = fire_i;
      if (fire_i) begin
        sum_d = 32'd0;
        cnt_d = 3'd0;
      end
    end else if (fire_i) begin
      sum_d = sum_new;
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 32'd0;
      cnt_q <= 3'd0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/core/cisd_pack.sv @@
// Result packer of the compressed integer stream decoder.
// Holds the mode register, passes values through in integer mode and pairs bit-reversed values into double patterns.
// Depends on cisd_pkg.
module cisd_pack
  import cisd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_mode_i,
  input  value_beat_t value_i,
  output logic        emit_o,
  output logic [63:0] data_o,
  output logic        is_double_o
);

  logic        mode_q;
  logic        have_q, have_d;
  logic [31:0] high_q, high_d;
  logic [31:0] rev;

  assign rev = bit_reverse32(value_i.value);

  always_comb begin
    have_d      = have_q;
    high_d      = high_q;
    emit_o      = 1'b0;
    data_o      = {32'd0, value_i.value};
    is_double_o = 1'b0;
    if (value_i.done) begin
      if (!mode_q) begin
        emit_o = 1'b1;
      end else if (!have_q) begin
        high_d = rev;
        have_d = 1'b1;
      end else begin
        emit_o      = 1'b1;
        data_o      = {high_q, rev};
        is_double_o = 1'b1;
        have_d      = 1'b0;
      end
    end
    // A mode write drops any half-built pair.
    if (cfg_we_i) begin
      have_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      have_q <= 1'b0;
      high_q <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      have_q <= have_d;
      high_q <= high_d;
    end
  end

endmodule

@@ rtl/core/compressed_int_stream_decoder_top.sv @@
// Top level of the compressed integer stream decoder.
// Instantiates cisd_accum and cisd_pack and holds the input and result registers.
// Depends on cisd_pkg.
//
// Usage: the input channel carries one stream byte per beat on stream_byte_i;
// a beat is taken at a rising edge with in_valid_i high and in_stall_o low.
// Each byte is captured in an input register; once the result register is free,
// the assembler and packer turn it, in one pass of logic, into at most one result
// that lands in the result register. A result beat leaves at an edge with
// out_valid_o high and out_stall_i low. Throughput is one byte per cycle while
// the receiver does not stall. Bytes that only extend a value, and the first
// value of a double pair, produce no result beat.
// When the receiver stalls, the result register holds its beat and the input
// register holds its byte, whether or not that byte would produce a result;
// in_stall_o is high while a byte waits and the result register is not free.
// The mode register is written over the cfg channel, always ready; a write
// drops a pending half of a double pair. Reset clears the mode to integer,
// the running sum, the byte count and both valid flags.
module compressed_int_stream_decoder_top
  import cisd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] decoded_value_o,
  output logic        value_is_double_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_value_mode_i
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_data_q;
  logic        out_double_q;
  logic        advance;
  logic        accept;
  logic        out_free;
  value_beat_t value_beat;
  logic        emit;
  logic [63:0] emit_data;
  logic        emit_double;

  // The result register is free when empty or being read this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  cisd_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .byte_i  (in_byte_q),
    .value_o (value_beat)
  );

  cisd_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_mode_i  (cfg_value_mode_i),
    .value_i     (value_beat),
    .emit_o      (emit),
    .data_o      (emit_data),
    .is_double_o (emit_double)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= stream_byte_i;
    end
    if (emit) begin
      out_data_q   <= emit_data;
      out_double_q <= emit_double;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign decoded_value_o   = out_data_q;
  assign value_is_double_o = out_double_q;

endmodule
